>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; empty bodies when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

>>> hw/rtl/skd_pkg.sv
// package for the seeded keystream decryptor: types, constants, state codes
// no dependencies
`default_nettype none
package skd_pkg;
	localparam int KEY_WORDS = 2560;
	localparam int MT_N = 312;
	localparam int MT_M = 156;
	localparam logic [63:0] MT_MUL = 64'd6364136223846793005;
	localparam logic [63:0] MT_MAT = 64'hB5026F5AA96619E9;
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_GEN = 2'd1;
	localparam logic [1:0] REQ_DEC = 2'd2;
	localparam logic [1:0] KIND_ACK = 2'd0;
	localparam logic [1:0] KIND_FIELD = 2'd1;
	localparam logic [1:0] KIND_BYTE = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [4:0]  slot;
		logic [31:0] word_value;
		logic        field_mode;
		logic [31:0] literal_index;
		logic [31:0] byte_pos;
		logic [7:0]  data_byte;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  field_slot;
		logic [31:0] value;
		logic        last;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SEL, ST_SEED_M, ST_SEED_W, ST_TW_RD, ST_TW_WR,
		ST_DRAW, ST_DRAW_T, ST_DEC_A, ST_DEC_B, ST_DEC_R, ST_FIELDS
	} state_t;

	function automatic logic [63:0] temper(input logic [63:0] x);
		logic [63:0] y;
		y = x ^ ((x >> 29) & 64'h5555555555555555);
		y = y ^ ((y << 17) & 64'h71D67FFFEDA60000);
		y = y ^ ((y << 37) & 64'hFFF7EEE000000000);
		y = y ^ (y >> 43);
		return y;
	endfunction
endpackage
`default_nettype wire

>>> hw/rtl/skd_mul64.sv
// 64x64 low-half multiplier, three 32x32 partial products accumulated in sequence
// depends on no package
`default_nettype none
`include "assert_macros.svh"
module skd_mul64 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      p
);
	logic [2:0]  step_q;
	logic [63:0] a_q, b_q, acc_q;
	logic [63:0] pp_s1;
	logic [31:0] xa, xb;

	// partial product select: ll, lh, hl
	always_comb begin
		xa = a_q[31:0];
		xb = b_q[31:0];
		case (step_q)
			3'd2: xb = b_q[63:32];
			3'd3: xa = a_q[63:32];
			default: ;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 3'd0;
		end else if (go) begin
			step_q <= 3'd1;
		end else if (step_q != 3'd0) begin
			step_q <= (step_q == 3'd4) ? 3'd0 : step_q + 3'd1;
		end
	end

	// operand, product and accumulator registers
	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end
		pp_s1 <= xa * xb;
		case (step_q)
			3'd2: acc_q <= pp_s1;
			3'd3: acc_q <= acc_q + {pp_s1[31:0], 32'd0};
			3'd4: acc_q <= acc_q + {pp_s1[31:0], 32'd0};
			default: ;
		endcase
	end

	assign done = (step_q == 3'd4);
	assign p = acc_q + {pp_s1[31:0], 32'd0};

	`ASSERT_NEXT(a_mul_done_clears, clk, arst_n, done, step_q == 3'd0)
	`ASSERT_IMPL(a_mul_range, clk, arst_n, 1'b1, step_q <= 3'd4)
	`ASSERT_NEXT(a_mul_go_start, clk, arst_n, go, step_q == 3'd1)
endmodule
`default_nettype wire

>>> hw/rtl/seeded_keystream_string_decryptor_core.sv
// Seeded keystream decryptor core: header writes, MT19937-64-style key fill, byte decrypt.
// Header write and unused requests: result word in the cycle after accept.
// Decrypt: states DEC_A, DEC_B, DEC_R, then the result word (two key reads on one port).
// Generate: seeding of word 0 and then 311 words, nine twists of 312 words, 2566 draws; ack
// after that, or five field words in field mode. One item at a time.
// Reset (arst_n low) clears control state; stores hold garbage until written.
`default_nettype none
`include "assert_macros.svh"
module seeded_keystream_string_decryptor_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire skd_pkg::req_t req,
	output logic               busy,
	output logic               strobe,
	output skd_pkg::rsp_t      rsp
);
	localparam logic [63:0] MT_MUL_OP = skd_pkg::MT_MUL;

	skd_pkg::state_t state_q, state_d;
	skd_pkg::req_t   req_q;

	logic [31:0] seed_q [18];
	logic [31:0] fld_q [5];
	logic [63:0] mt_mem [skd_pkg::MT_N];
	logic [63:0] key_mem [skd_pkg::KEY_WORDS];

	logic [8:0]  idx_q;       // generator index
	logic [8:0]  k_q;         // seed / twist counter
	logic [11:0] cnt_q;       // draw counter
	logic [63:0] prev_q, x0_q, mt_rd_q, mt_rd2_q;
	logic [63:0] d_q [6];
	logic [2:0]  fo_q;
	logic [63:0] key_rd_q;
	logic [7:0]  ka_q;
	logic [63:0] mul_p;
	logic        mul_done, mul_go;
	logic        rsp_v_q;
	logic        accept;
	skd_pkg::rsp_t rsp_q;

	// mt memory addressing
	logic [8:0] mt_ra, mt_rb, mt_wa;
	logic [63:0] mt_wd;
	logic        mt_we;
	logic [11:0] key_ra;
	logic [14:0] ja, jb;

	skd_mul64 u_mul (
		.clk(clk), .arst_n(arst_n), .go(mul_go),
		.a(MT_MUL_OP), .b(prev_q ^ (prev_q >> 62)), .done(mul_done), .p(mul_p)
	);

	// residue mod 5 of a 21-bit value: 16 is 1 mod 5, so fold the nibbles
	function automatic logic [2:0] mod5(input logic [20:0] v);
		logic [6:0] s1;
		logic [4:0] s2;
		s1 = 7'(v[3:0]) + 7'(v[7:4]) + 7'(v[11:8]) + 7'(v[15:12]) + 7'(v[20:16]);
		s2 = 5'(s1[6:4]) + 5'(s1[3:0]);
		if (s2 >= 5'd15)
			s2 = s2 - 5'd15;
		else if (s2 >= 5'd10)
			s2 = s2 - 5'd10;
		else if (s2 >= 5'd5)
			s2 = s2 - 5'd5;
		return s2[2:0];
	endfunction

	// word accepted only when idle with no result pending
	assign accept = (state_q == skd_pkg::ST_IDLE) && start && !rsp_v_q;

	// key byte addresses: mod 0x5000 and mod 0x2800 as residue mod 5 above a bit mask
	always_comb begin
		logic [32:0] t;
		t = {1'b0, req_q.byte_pos} + 33'h1400;
		ja = {mod5(t[32:12]), t[11:0]};
		jb = {1'b0, mod5(req_q.literal_index[31:11]), req_q.literal_index[10:0]}
			+ {1'b0, mod5(req_q.byte_pos[31:11]), req_q.byte_pos[10:0]};
	end

	// twist wrap indices
	always_comb begin
		mt_ra = (k_q == 9'(skd_pkg::MT_N - 1)) ? 9'd0 : k_q + 9'd1;
		mt_rb = (k_q >= 9'(skd_pkg::MT_N - skd_pkg::MT_M)) ?
			k_q - 9'(skd_pkg::MT_N - skd_pkg::MT_M) : k_q + 9'(skd_pkg::MT_M);
	end

	// next state and control
	always_comb begin
		logic [63:0] x, xa;
		state_d = state_q;
		mul_go = 1'b0;
		mt_we = 1'b0;
		mt_wa = k_q;
		mt_wd = mul_p + {55'd0, k_q};
		key_ra = ja[14:3];
		x = {x0_q[63:31], mt_rd_q[30:0]};
		xa = (x >> 1) ^ (x[0] ? skd_pkg::MT_MAT : 64'd0);
		unique case (state_q)
			skd_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (req.req_type)
						skd_pkg::REQ_GEN: state_d = skd_pkg::ST_SEL;
						skd_pkg::REQ_DEC: state_d = skd_pkg::ST_DEC_A;
						default: state_d = skd_pkg::ST_IDLE;
					endcase
				end
			end
			skd_pkg::ST_SEL: begin
				mt_we = 1'b1;
				mt_wa = '0;
				mt_wd = {seed_q[5'(seed_q[0][3:0])], seed_q[5'(seed_q[17][3:0]) + 5'd2]};
				state_d = skd_pkg::ST_SEED_M;
				mul_go = 1'b0;
			end
			skd_pkg::ST_SEED_M: begin
				mul_go = 1'b1;
				state_d = skd_pkg::ST_SEED_W;
			end
			skd_pkg::ST_SEED_W: begin
				if (mul_done) begin
					mt_we = 1'b1;
					state_d = (k_q == 9'(skd_pkg::MT_N - 1)) ? skd_pkg::ST_DRAW
						: skd_pkg::ST_SEED_M;
				end
			end
			skd_pkg::ST_TW_RD: state_d = skd_pkg::ST_TW_WR;
			skd_pkg::ST_TW_WR: begin
				mt_we = 1'b1;
				mt_wd = mt_rd2_q ^ xa;
				state_d = (k_q == 9'(skd_pkg::MT_N - 1)) ? skd_pkg::ST_DRAW
					: skd_pkg::ST_TW_RD;
			end
			skd_pkg::ST_DRAW: begin
				state_d = (idx_q == 9'(skd_pkg::MT_N)) ? skd_pkg::ST_TW_RD
					: skd_pkg::ST_DRAW_T;
			end
			skd_pkg::ST_DRAW_T: begin
				if (cnt_q == 12'(skd_pkg::KEY_WORDS + 5))
					state_d = req_q.field_mode ? skd_pkg::ST_FIELDS : skd_pkg::ST_IDLE;
				else
					state_d = skd_pkg::ST_DRAW;
			end
			skd_pkg::ST_DEC_A: begin
				key_ra = ja[14:3];
				state_d = skd_pkg::ST_DEC_B;
			end
			skd_pkg::ST_DEC_B: begin
				key_ra = jb[14:3];
				state_d = skd_pkg::ST_DEC_R;
			end
			skd_pkg::ST_DEC_R: state_d = skd_pkg::ST_IDLE;
			skd_pkg::ST_FIELDS: if (fo_q == 3'd4) state_d = skd_pkg::ST_IDLE;
			default: state_d = skd_pkg::ST_IDLE;
		endcase
	end

	// generator state memory: one write, two registered reads
	// the twist takes word k from the previous step's k+1 read; word 0 is read on entry
	always_ff @(posedge clk) begin
		if (mt_we) mt_mem[mt_wa] <= mt_wd;
		mt_rd_q <= mt_mem[(state_q == skd_pkg::ST_DRAW) ? idx_q : mt_ra];
		mt_rd2_q <= mt_mem[(state_q == skd_pkg::ST_DRAW) ? 9'd0 : mt_rb];
		if (state_q == skd_pkg::ST_TW_RD && k_q == 9'd0)
			x0_q <= mt_rd2_q;
		if (state_q == skd_pkg::ST_TW_WR)
			x0_q <= mt_rd_q;
	end

	// key store: write on draw, one read port
	always_ff @(posedge clk) begin
		if (state_q == skd_pkg::ST_DRAW_T && cnt_q >= 12'd6)
			key_mem[cnt_q - 12'd6] <= skd_pkg::temper(mt_rd_q);
		key_rd_q <= key_mem[key_ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skd_pkg::ST_IDLE;
			idx_q <= '0;
			rsp_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rsp_v_q <= 1'b0;
			if (accept
					&& req.req_type != skd_pkg::REQ_GEN && req.req_type != skd_pkg::REQ_DEC)
				rsp_v_q <= 1'b1;
			if (state_q == skd_pkg::ST_DEC_R || state_q == skd_pkg::ST_FIELDS)
				rsp_v_q <= 1'b1;
			if (state_q == skd_pkg::ST_DRAW_T && state_d == skd_pkg::ST_IDLE)
				rsp_v_q <= 1'b1;
			if (state_q == skd_pkg::ST_SEL) idx_q <= 9'(skd_pkg::MT_N);
			if (state_q == skd_pkg::ST_TW_WR && state_d == skd_pkg::ST_DRAW) idx_q <= '0;
			if (state_q == skd_pkg::ST_DRAW_T) idx_q <= idx_q + 9'd1;
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			cnt_q <= '0;
			fo_q <= '0;
			if (req.req_type == skd_pkg::REQ_WRITE) begin
				if (req.slot < 5'd18) seed_q[req.slot] <= req.word_value;
				else if (req.slot < 5'd23) fld_q[3'(req.slot - 5'd18)] <= req.word_value;
			end
			rsp_q <= '{kind: skd_pkg::KIND_ACK, field_slot: 3'd0, value: 32'd0, last: 1'b1};
		end
		if (state_q == skd_pkg::ST_SEL) begin
			k_q <= '0;
			prev_q <= {seed_q[5'(seed_q[0][3:0])], seed_q[5'(seed_q[17][3:0]) + 5'd2]};
		end
		if (state_q == skd_pkg::ST_SEED_M) k_q <= k_q + 9'd1;
		if (state_q == skd_pkg::ST_SEED_W && mul_done) prev_q <= mt_wd;
		if (state_q == skd_pkg::ST_DRAW && state_d == skd_pkg::ST_TW_RD) k_q <= '0;
		if (state_q == skd_pkg::ST_TW_WR) k_q <= k_q + 9'd1;
		if (state_q == skd_pkg::ST_DRAW_T) begin
			cnt_q <= cnt_q + 12'd1;
			if (cnt_q < 12'd6) d_q[3'(cnt_q)] <= skd_pkg::temper(mt_rd_q);
			rsp_q <= '{kind: skd_pkg::KIND_ACK, field_slot: 3'd0, value: 32'd0, last: 1'b1};
		end
		if (state_q == skd_pkg::ST_DEC_B) ka_q <= key_rd_q[8*ja[2:0] +: 8];
		if (state_q == skd_pkg::ST_DEC_R)
			rsp_q <= '{kind: skd_pkg::KIND_BYTE, field_slot: 3'd0,
				value: {24'd0, req_q.data_byte ^ ka_q
					^ (key_rd_q[8*jb[2:0] +: 8] + req_q.byte_pos[7:0])},
				last: 1'b1};
		if (state_q == skd_pkg::ST_FIELDS) begin
			logic [31:0] nv;
			nv = fld_q[fo_q] ^ d_q[(fo_q < 3'd2) ? fo_q : fo_q + 3'd1][31:0];
			fld_q[fo_q] <= nv;
			rsp_q <= '{kind: skd_pkg::KIND_FIELD, field_slot: fo_q, value: nv,
				last: fo_q == 3'd4};
			fo_q <= fo_q + 3'd1;
		end
	end

	assign busy = (state_q != skd_pkg::ST_IDLE) || rsp_v_q;
	assign strobe = rsp_v_q;
	assign rsp = rsp_q;

	`ASSERT_IMPL(a_no_start_busy, clk, arst_n, state_q != skd_pkg::ST_IDLE, busy)
	`ASSERT_IMPL(a_idx_range, clk, arst_n, 1'b1, idx_q <= 9'(skd_pkg::MT_N))
	`ASSERT_IMPL(a_cnt_range, clk, arst_n, state_q == skd_pkg::ST_DRAW_T, cnt_q <= 12'(skd_pkg::KEY_WORDS + 5))
	`ASSERT_NEXT(a_strobe_single, clk, arst_n, strobe && rsp.last, !strobe)
endmodule
`default_nettype wire
